>>> rtl/oae_pkg.sv
// Shared types and codes for the ordered array engine.
package oae_pkg;

	// Operation codes carried by a request transaction.
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_REVERSE = 2'd3
	} op_t;

	// Status codes returned with every result transaction.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	// Request transaction payload.
	typedef struct packed {
		op_t                operation;
		logic [7:0]         position;
		logic signed [31:0] value;
	} oae_req_t;

	// Result transaction payload.
	typedef struct packed {
		status_t    status;
		logic [6:0] found_index;
		logic [7:0] length;
	} oae_rsp_t;

	// Pointer moves requested by the controller.
	typedef enum logic [1:0] {
		PTR_HOLD = 2'd0,
		PTR_DOWN = 2'd1,
		PTR_UP   = 2'd2,
		PTR_SWAP = 2'd3
	} ptr_t;

	// Memory write sources requested by the controller.
	typedef enum logic [2:0] {
		WR_NONE    = 3'd0,
		WR_SHIFT   = 3'd1,
		WR_WORD    = 3'd2,
		WR_SWAP_LO = 3'd3,
		WR_SWAP_HI = 3'd4
	} wsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd;
		ptr_t    ptr;
		wsel_t   wsel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    fin;
		logic    found;
		status_t status;
	} oae_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic full;
		logic bad_pos;
		logic no_work;
		logic at_end;
		logic hit;
		logic scan_over;
		logic rev_more;
	} oae_stat_t;

endpackage

>>> rtl/oae_dp.sv
// Datapath: entry memory, pointers, entry count, compare and result registers.
module oae_dp import oae_pkg::*; #(
	parameter int CAPACITY  = 128,
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  oae_req_t  req,
	input  oae_cmd_t  cmd,
	output oae_stat_t stat,
	output logic      done,
	output oae_rsp_t  rsp
);

	localparam int AW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

	// Entry storage; only entries below the count are ever read.
	logic [WORD_BITS-1:0] mem [CAPACITY];

	// Latched request.
	op_t                  op_q;
	logic [7:0]           pos_q;
	logic [WORD_BITS-1:0] word_q;

	// Pointers and shift bookkeeping.
	logic [AW-1:0] lo_q, hi_q, end_q, waddr_q, cmp_idx_q;
	logic          wpend_q, rdv_q, rdlast_q;
	logic [CW-1:0] count_q, count_nxt;

	// Registered read data and swap holding register.
	logic [WORD_BITS-1:0] rdata_a_q, rdata_b_q, sav_q;

	// Result registers.
	logic     done_q;
	oae_rsp_t rsp_q;

	// Widened operands for position checks and pointer setup.
	logic [CMPW-1:0] pos_w, n_w, pos_in_w, n_m1_w, pos_in_m1_w;
	logic            is_shift_op;

	// Memory write port selection.
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	assign pos_w       = CMPW'(pos_q);
	assign n_w         = CMPW'(count_q);
	assign pos_in_w    = CMPW'(req.position);
	assign n_m1_w      = n_w - CMPW'(1);
	assign pos_in_m1_w = pos_in_w - CMPW'(1);
	assign is_shift_op = (op_q == OP_INSERT) || (op_q == OP_DELETE);

	// Status toward the controller.
	always_comb begin
		stat.op        = op_q;
		stat.full      = (count_q == CW'(CAPACITY));
		stat.at_end    = (lo_q == end_q);
		stat.hit       = rdv_q && (rdata_a_q == word_q);
		stat.scan_over = rdv_q && rdlast_q;
		stat.rev_more  = (lo_q < hi_q);
		stat.bad_pos   = 1'b0;
		stat.no_work   = 1'b0;
		case (op_q)
			OP_INSERT: begin
				stat.bad_pos = (pos_w == '0) || (pos_w > n_w + CMPW'(1));
				stat.no_work = (pos_w == n_w + CMPW'(1));
			end
			OP_DELETE: begin
				stat.bad_pos = (pos_w == '0) || (pos_w > n_w);
				stat.no_work = (pos_w == n_w);
			end
			OP_SEARCH: begin
				stat.no_work = (count_q == '0);
			end
			default: begin
				stat.no_work = (count_q <= CW'(1));
			end
		endcase
	end

	// Write port source mux; a shift write stores the registered read data at the registered write address.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = waddr_q;
		wr_data = rdata_a_q;
		case (cmd.wsel)
			WR_SHIFT: begin
				wr_en = wpend_q;
			end
			WR_WORD: begin
				wr_en   = 1'b1;
				wr_addr = end_q;
				wr_data = word_q;
			end
			WR_SWAP_LO: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rdata_b_q;
			end
			WR_SWAP_HI: begin
				wr_en   = 1'b1;
				wr_data = sav_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Memory with one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_a_q <= mem[lo_q];
			rdata_b_q <= mem[hi_q];
		end
	end

	// Request capture, pointer setup and pointer moves.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			pos_q  <= req.position;
			word_q <= WORD_BITS'(req.value);
			hi_q   <= n_m1_w[AW-1:0];
			case (req.operation)
				OP_INSERT: begin
					lo_q  <= n_m1_w[AW-1:0];
					end_q <= pos_in_m1_w[AW-1:0];
				end
				OP_DELETE: begin
					lo_q  <= pos_in_w[AW-1:0];
					end_q <= n_m1_w[AW-1:0];
				end
				default: begin
					lo_q  <= '0;
					end_q <= n_m1_w[AW-1:0];
				end
			endcase
		end else begin
			case (cmd.ptr)
				PTR_DOWN: lo_q <= lo_q - AW'(1);
				PTR_UP:   lo_q <= lo_q + AW'(1);
				PTR_SWAP: begin
					lo_q <= lo_q + AW'(1);
					hi_q <= hi_q - AW'(1);
				end
				default: lo_q <= lo_q;
			endcase
		end
		if (cmd.rd) begin
			cmp_idx_q <= lo_q;
			rdlast_q  <= (lo_q == end_q);
		end
		if (cmd.ptr == PTR_SWAP) begin
			waddr_q <= hi_q;
		end else if (cmd.rd && is_shift_op) begin
			waddr_q <= (op_q == OP_INSERT) ? lo_q + AW'(1) : lo_q - AW'(1);
		end
		if (cmd.wsel == WR_SWAP_LO) begin
			sav_q <= rdata_a_q;
		end
		if (cmd.fin) begin
			rsp_q.status      <= cmd.status;
			rsp_q.found_index <= cmd.found ? 7'(cmp_idx_q) : 7'd0;
			rsp_q.length      <= 8'(count_nxt);
		end
	end

	// Next entry count.
	always_comb begin
		count_nxt = count_q;
		if (cmd.cnt_inc) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// Control flags and the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wpend_q <= 1'b0;
			rdv_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			wpend_q <= cmd.rd && is_shift_op;
			rdv_q   <= cmd.rd;
			done_q  <= cmd.fin;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> rtl/oae_ctrl.sv
// Controller: sequences each operation over the datapath.
module oae_ctrl import oae_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  oae_stat_t stat,
	output oae_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT,
		S_FLUSH,
		S_PUT,
		S_SRCH,
		S_REV_RD,
		S_REV_WA,
		S_REV_WB
	} state_t;

	state_t state_q, state_nxt;
	logic   busy_q;

	// Commands and next state for the current step.
	always_comb begin
		cmd         = '0;
		cmd.ptr     = PTR_HOLD;
		cmd.wsel    = WR_NONE;
		cmd.status  = ST_OK;
		state_nxt   = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_FULL;
							state_nxt  = S_IDLE;
						end else if (stat.bad_pos) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_BADPOS;
							state_nxt  = S_IDLE;
						end else if (stat.no_work) begin
							state_nxt = S_PUT;
						end else begin
							state_nxt = S_SHIFT;
						end
					end
					OP_DELETE: begin
						if (stat.bad_pos) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_BADPOS;
							state_nxt  = S_IDLE;
						end else if (stat.no_work) begin
							cmd.fin     = 1'b1;
							cmd.cnt_dec = 1'b1;
							state_nxt   = S_IDLE;
						end else begin
							state_nxt = S_SHIFT;
						end
					end
					OP_SEARCH: begin
						if (stat.no_work) begin
							cmd.fin    = 1'b1;
							cmd.status = ST_MISS;
							state_nxt  = S_IDLE;
						end else begin
							state_nxt = S_SRCH;
						end
					end
					default: begin
						if (stat.no_work) begin
							cmd.fin   = 1'b1;
							state_nxt = S_IDLE;
						end else begin
							state_nxt = S_REV_RD;
						end
					end
				endcase
			end
			// Move one entry per cycle: read here, write in the cycle after.
			S_SHIFT: begin
				cmd.rd   = 1'b1;
				cmd.wsel = WR_SHIFT;
				cmd.ptr  = (stat.op == OP_INSERT) ? PTR_DOWN : PTR_UP;
				if (stat.at_end) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.wsel = WR_SHIFT;
				if (stat.op == OP_INSERT) begin
					state_nxt = S_PUT;
				end else begin
					cmd.fin     = 1'b1;
					cmd.cnt_dec = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			S_PUT: begin
				cmd.wsel    = WR_WORD;
				cmd.cnt_inc = 1'b1;
				cmd.fin     = 1'b1;
				state_nxt   = S_IDLE;
			end
			// Read one entry per cycle and compare the previous one.
			S_SRCH: begin
				if (stat.hit) begin
					cmd.fin   = 1'b1;
					cmd.found = 1'b1;
					state_nxt = S_IDLE;
				end else if (stat.scan_over) begin
					cmd.fin    = 1'b1;
					cmd.status = ST_MISS;
					state_nxt  = S_IDLE;
				end else begin
					cmd.rd  = 1'b1;
					cmd.ptr = PTR_UP;
				end
			end
			S_REV_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = S_REV_WA;
			end
			S_REV_WA: begin
				cmd.wsel  = WR_SWAP_LO;
				cmd.ptr   = PTR_SWAP;
				state_nxt = S_REV_WB;
			end
			// Finish one pair and fetch the next in the same cycle.
			S_REV_WB: begin
				cmd.wsel = WR_SWAP_HI;
				if (stat.rev_more) begin
					cmd.rd    = 1'b1;
					state_nxt = S_REV_WA;
				end else begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy_q  <= (state_nxt != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

>>> rtl/ordered_array_engine.sv
// Top level of the ordered array engine: controller plus datapath.
//
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        req  (operation, position, value)
// result    out        done, one cycle      rsp  (status, found_index, length)
//
// Each request transaction gives exactly one result transaction. An insert at
// the end or a delete of the last entry moves no entries, and a search stops
// at its first hit. Shifts move one entry per cycle through the single write
// port of the memory. Reset clears the count and control state; entry
// contents need no clearing. The result strobe cannot be stalled; a new
// request may be accepted in the cycle its result is shown.
module ordered_array_engine import oae_pkg::*; #(
	parameter int CAPACITY  = 128,
	parameter int WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  oae_req_t req,
	output logic     done,
	output oae_rsp_t rsp
);

	oae_cmd_t  cmd;
	oae_stat_t stat;
	logic      ctrl_busy;

	// Sequencer.
	oae_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	// Storage and arithmetic.
	oae_dp #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	assign busy = ctrl_busy;

endmodule
